@@ hdl/bptc_pkg.sv @@
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types, constants and register codes of the barometer compensation.
// ----------------------------------------------------------------------------
`default_nettype none

package bptc_pkg;

	localparam int DATA_W     = 32;
	localparam int DIV_STAGES = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int UP_W       = 24;

	localparam logic signed [31:0] C_B6_OFFSET = 32'sd4000;
	localparam logic signed [31:0] C_P_K1      = 32'sd3038;
	localparam logic signed [31:0] C_P_K2      = -32'sd7357;
	localparam logic signed [31:0] C_P_K3      = 32'sd3781;
	localparam logic signed [31:0] C_AC4_BIAS  = 32'sd32768;
	localparam logic [31:0]        C_B7_SCALE  = 32'd50000;
	localparam logic [31:0]        C_MSB32     = 32'h8000_0000;
	localparam logic signed [31:0] C_T_MAX     = 32'sd32767;
	localparam logic signed [31:0] C_T_MIN     = -32'sd32768;
	localparam logic signed [31:0] C_P_MAX     = 32'sd1048575;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AC1_AC2   = 3'd0,
		REG_AC3_AC4   = 3'd1,
		REG_AC5_AC6   = 3'd2,
		REG_B1_B2     = 3'd3,
		REG_MC_MD     = 3'd4,
		REG_OVERSAMPL = 3'd5
	} cfg_reg_e;

	// Sideband that rides through the temperature divider
	typedef struct packed {
		logic signed [31:0] x1;
		logic               qneg;
		logic               fault;
		logic [UP_W-1:0]    up;
	} side1_t;

	// Sideband that rides through the pressure divider
	typedef struct packed {
		logic signed [15:0] t16;
		logic               fault;
		logic               post_shift;
	} side2_t;

	localparam int SIDE_W = $bits(side1_t);

	// Values carried along the b-coefficient stages
	typedef struct packed {
		logic signed [15:0] t16;
		logic               fault;
		logic [UP_W-1:0]    up;
	} carry_t;

	function automatic logic signed [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction

endpackage

`default_nettype wire

@@ hdl/bptc_if.sv @@
// ----------------------------------------------------------------------------
// bptc interfaces
// Sample, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bptc_sample_if;
	logic        valid;
	logic        ready;
	logic [15:0] raw_temp;
	logic [23:0] raw_press;
	modport source (output valid, output raw_temp, output raw_press, input ready);
	modport sink   (input valid, input raw_temp, input raw_press, output ready);
endinterface

interface bptc_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] temp_tenths;
	logic [19:0]        pressure_pa;
	logic               div_fault;
	modport source (output valid, output temp_tenths, output pressure_pa,
		output div_fault, input ready);
	modport sink   (input valid, input temp_tenths, input pressure_pa,
		input div_fault, output ready);
endinterface

interface bptc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/bptc_udiv.sv @@
// ----------------------------------------------------------------------------
// bptc_udiv
// Unsigned 32/32 restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_udiv
	import bptc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [31:0]       dividend,
	input  wire logic [31:0]       divisor,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_valid,
	output logic [31:0]            quotient,
	output logic [SIDE_W-1:0]      out_side
);

	// dq holds the unused dividend bits on top, quotient bits shift in below
	logic              vld_s  [DIV_STAGES];
	logic [31:0]       rem_s  [DIV_STAGES];
	logic [31:0]       dq_s   [DIV_STAGES];
	logic [31:0]       dvs_s  [DIV_STAGES];
	logic [SIDE_W-1:0] side_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic              vld_in;
		logic [31:0]       rem_in;
		logic [31:0]       dq_in;
		logic [31:0]       dvs_in;
		logic [SIDE_W-1:0] side_in;
		logic [33:0]       trial;
		logic [31:0]       rem_nx;
		logic [31:0]       dq_nx;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = '0;
			assign dq_in   = dividend;
			assign dvs_in  = divisor;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign dq_in   = dq_s[k-1];
			assign dvs_in  = dvs_s[k-1];
			assign side_in = side_s[k-1];
		end

		always_comb begin
			trial = {1'b0, rem_in, dq_in[31]} - {2'b00, dvs_in};
			if (!trial[33]) begin
				rem_nx = trial[31:0];
				dq_nx  = {dq_in[30:0], 1'b1};
			end else begin
				rem_nx = {rem_in[30:0], dq_in[31]};
				dq_nx  = {dq_in[30:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_nx;
				dq_s[k]   <= dq_nx;
				dvs_s[k]  <= dvs_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign quotient  = dq_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ hdl/baro_temp_pressure_compensation_unit.sv @@
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_unit
// Integer barometer compensation: raw temperature and pressure in,
// temperature in 0.1 C and pressure in Pa out, with divide fault flag.
// ----------------------------------------------------------------------------
// Pipeline: 2 front stages, 32-stage divider, 6 coefficient stages,
//   32-stage divider, 2 polynomial stages, output register.
// Throughput: one sample per cycle; the whole pipe freezes while the output
//   register holds a result that is not taken.
// Reset: arst_n clears all valid bits, calibration words to 0, oversampling 3.
`default_nettype none

module baro_temp_pressure_compensation_unit
	import bptc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	bptc_sample_if.sink     sample,
	bptc_result_if.source   result,
	bptc_cfg_if.sink        cfg
);

	// ------------------------------------------------------------------
	// Configuration registers. The user must write them only while idle; the
	// block does not enforce it, and every stage reads them directly.
	// ------------------------------------------------------------------
	logic [31:0] cal_ac1_ac2_q;
	logic [31:0] cal_ac3_ac4_q;
	logic [31:0] cal_ac5_ac6_q;
	logic [31:0] cal_b1_b2_q;
	logic [31:0] cal_mc_md_q;
	logic [1:0]  oss_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_ac1_ac2_q <= '0;
			cal_ac3_ac4_q <= '0;
			cal_ac5_ac6_q <= '0;
			cal_b1_b2_q   <= '0;
			cal_mc_md_q   <= '0;
			oss_q         <= 2'd3;
		end else if (cfg.valid) begin
			unique case (cfg_reg_e'(cfg.index))
				REG_AC1_AC2:   cal_ac1_ac2_q <= cfg.data;
				REG_AC3_AC4:   cal_ac3_ac4_q <= cfg.data;
				REG_AC5_AC6:   cal_ac5_ac6_q <= cfg.data;
				REG_B1_B2:     cal_b1_b2_q   <= cfg.data;
				REG_MC_MD:     cal_mc_md_q   <= cfg.data;
				REG_OVERSAMPL: oss_q         <= cfg.data[1:0];
				default:       ; // unused index: write dropped
			endcase
		end
	end

	// Calibration fields, sign or zero extended to 32 bits
	logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [31:0]        ac4, ac5, ac6;

	assign ac1 = sx16(cal_ac1_ac2_q[31:16]);
	assign ac2 = sx16(cal_ac1_ac2_q[15:0]);
	assign ac3 = sx16(cal_ac3_ac4_q[31:16]);
	assign ac4 = {16'd0, cal_ac3_ac4_q[15:0]};
	assign ac5 = {16'd0, cal_ac5_ac6_q[31:16]};
	assign ac6 = {16'd0, cal_ac5_ac6_q[15:0]};
	assign b1  = sx16(cal_b1_b2_q[31:16]);
	assign b2  = sx16(cal_b1_b2_q[15:0]);
	assign mc  = sx16(cal_mc_md_q[31:16]);
	assign md  = sx16(cal_mc_md_q[15:0]);

	// Global advance: everything moves unless a finished result is stuck
	logic out_valid_q;
	logic adv;

	assign adv          = !out_valid_q || result.ready;
	assign sample.ready = adv;

	// ------------------------------------------------------------------
	// s1: (ut - ac6) * ac5, oversampling shift of raw pressure
	// ------------------------------------------------------------------
	logic               vld_s1;
	logic signed [31:0] prod_s1;
	logic [UP_W-1:0]    up_s1;
	logic [31:0]        ut_diff;
	logic [3:0]         up_shift;

	assign ut_diff  = {16'd0, sample.raw_temp} - ac6;
	assign up_shift = 4'd8 - {2'b00, oss_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= ut_diff * ac5;
			up_s1   <= sample.raw_press >> up_shift;
		end
	end

	// ------------------------------------------------------------------
	// s2: x1 = prod / 32768 (toward zero), den = x1 + md, set up the
	// magnitude divide of mc * 2048 by den
	// ------------------------------------------------------------------
	logic signed [31:0] x1_t;
	logic signed [31:0] den;
	logic signed [31:0] num;
	logic [31:0]        num_mag, den_mag;
	side1_t             side1_nx;

	logic               vld_s2;
	logic [31:0]        dvd_s2;
	logic [31:0]        dvs_s2;
	side1_t             side1_s2;

	always_comb begin
		x1_t    = prod_s1[31] ? ((prod_s1 + 32'sd32767) >>> 15) : (prod_s1 >>> 15);
		den     = x1_t + md;
		num     = mc <<< 11;
		num_mag = num[31] ? 32'(-num) : 32'(num);
		den_mag = den[31] ? 32'(-den) : 32'(den);
		side1_nx.x1    = x1_t;
		side1_nx.qneg  = num[31] ^ den[31];
		side1_nx.fault = (den == 32'sd0);
		side1_nx.up    = up_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_s2   <= num_mag;
			dvs_s2   <= den_mag;
			side1_s2 <= side1_nx;
		end
	end

	// ------------------------------------------------------------------
	// Temperature divider
	// ------------------------------------------------------------------
	logic              d1_valid;
	logic [31:0]       d1_q;
	logic [SIDE_W-1:0] d1_side_raw;
	side1_t            d1_side;

	bptc_udiv u_div_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s2),
		.dividend  (dvd_s2),
		.divisor   (dvs_s2),
		.in_side   (SIDE_W'(side1_s2)),
		.out_valid (d1_valid),
		.quotient  (d1_q),
		.out_side  (d1_side_raw)
	);

	assign d1_side = side1_t'(d1_side_raw);

	// ------------------------------------------------------------------
	// s3: b5, temperature (saturated), b6
	// ------------------------------------------------------------------
	logic signed [31:0] x2_t, b5, t_sum, t_val;
	logic signed [15:0] t16;

	always_comb begin
		x2_t  = d1_side.qneg ? -$signed(d1_q) : $signed(d1_q);
		b5    = d1_side.x1 + x2_t;
		t_sum = b5 + 32'sd8;
		t_val = t_sum[31] ? ((t_sum + 32'sd15) >>> 4) : (t_sum >>> 4);
		if (t_val > C_T_MAX) begin
			t16 = C_T_MAX[15:0];
		end else if (t_val < C_T_MIN) begin
			t16 = C_T_MIN[15:0];
		end else begin
			t16 = t_val[15:0];
		end
	end

	logic               vld_s3;
	logic signed [31:0] b6_s3;
	carry_t             carry_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= d1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b6_s3          <= b5 - C_B6_OFFSET;
			carry_s3.t16   <= t16;
			carry_s3.fault <= d1_side.fault;
			carry_s3.up    <= d1_side.up;
		end
	end

	// ------------------------------------------------------------------
	// s4: b6 products
	// ------------------------------------------------------------------
	logic               vld_s4;
	logic signed [31:0] b6sq_s4, ac2b6_s4, ac3b6_s4;
	carry_t             carry_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b6sq_s4  <= b6_s3 * b6_s3;
			ac2b6_s4 <= ac2 * b6_s3;
			ac3b6_s4 <= ac3 * b6_s3;
			carry_s4 <= carry_s3;
		end
	end

	// ------------------------------------------------------------------
	// s5: b6^2 >> 12 times b2 and b1
	// ------------------------------------------------------------------
	logic signed [31:0] bsq;
	logic               vld_s5;
	logic signed [31:0] b2bsq_s5, b1bsq_s5, ac2b6_s5, ac3b6_s5;
	carry_t             carry_s5;

	assign bsq = b6sq_s4 >>> 12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b2bsq_s5 <= b2 * bsq;
			b1bsq_s5 <= b1 * bsq;
			ac2b6_s5 <= ac2b6_s4;
			ac3b6_s5 <= ac3b6_s4;
			carry_s5 <= carry_s4;
		end
	end

	// ------------------------------------------------------------------
	// s6: b3 and the ac4 factor (x3 + 32768)
	// ------------------------------------------------------------------
	logic signed [31:0] x3_b, b3_a, b3_b, b3_c, b3, x3_c, ac4_fac;

	always_comb begin
		x3_b    = (b2bsq_s5 >>> 11) + (ac2b6_s5 >>> 11);
		b3_a    = (ac1 <<< 2) + x3_b;
		b3_b    = b3_a <<< oss_q;
		b3_c    = b3_b + 32'sd2;
		b3      = b3_c[31] ? ((b3_c + 32'sd3) >>> 2) : (b3_c >>> 2);
		x3_c    = ((ac3b6_s5 >>> 13) + (b1bsq_s5 >>> 16) + 32'sd2) >>> 2;
		ac4_fac = x3_c + C_AC4_BIAS;
	end

	logic               vld_s6;
	logic signed [31:0] b3_s6, ac4fac_s6;
	carry_t             carry_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b3_s6     <= b3;
			ac4fac_s6 <= ac4_fac;
			carry_s6  <= carry_s5;
		end
	end

	// ------------------------------------------------------------------
	// s7: b4 (unsigned) and up - b3
	// ------------------------------------------------------------------
	logic [31:0] b4_prod;
	logic        vld_s7;
	logic [31:0] b4_s7, diff_s7;
	carry_t      carry_s7;

	assign b4_prod = ac4 * 32'(ac4fac_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b4_s7    <= b4_prod >> 15;
			diff_s7  <= {8'd0, carry_s6.up} - 32'(b3_s6);
			carry_s7 <= carry_s6;
		end
	end

	// ------------------------------------------------------------------
	// s8: b7 and the pressure divide setup. Below 2^31 the dividend is
	// doubled up front, otherwise the quotient is doubled afterwards.
	// ------------------------------------------------------------------
	logic [31:0] b7;
	side2_t      side2_nx;

	logic        vld_s8;
	logic [31:0] dvd_s8, dvs_s8;
	side2_t      side2_s8;

	always_comb begin
		b7                  = diff_s7 * (C_B7_SCALE >> oss_q);
		side2_nx.t16        = carry_s7.t16;
		side2_nx.fault      = carry_s7.fault || (b4_s7 == 32'd0);
		side2_nx.post_shift = (b7 >= C_MSB32);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_s8   <= side2_nx.post_shift ? b7 : {b7[30:0], 1'b0};
			dvs_s8   <= b4_s7;
			side2_s8 <= side2_nx;
		end
	end

	// ------------------------------------------------------------------
	// Pressure divider
	// ------------------------------------------------------------------
	logic              d2_valid;
	logic [31:0]       d2_q;
	logic [SIDE_W-1:0] d2_side_raw;
	side2_t            d2_side;

	bptc_udiv u_div_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s8),
		.dividend  (dvd_s8),
		.divisor   (dvs_s8),
		.in_side   (SIDE_W'(side2_s8)),
		.out_valid (d2_valid),
		.quotient  (d2_q),
		.out_side  (d2_side_raw)
	);

	assign d2_side = side2_t'(d2_side_raw[$bits(side2_t)-1:0]);

	// ------------------------------------------------------------------
	// s9: p, (p >> 8)^2, -7357 * p
	// ------------------------------------------------------------------
	logic signed [31:0] p_raw, p_hi;

	assign p_raw = d2_side.post_shift ? $signed({d2_q[30:0], 1'b0}) : $signed(d2_q);
	assign p_hi  = p_raw >>> 8;

	logic               vld_s9;
	logic signed [31:0] p_s9, x1sq_s9, m2_s9;
	side2_t             side2_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s9 <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s9     <= p_raw;
			x1sq_s9  <= p_hi * p_hi;
			m2_s9    <= C_P_K2 * p_raw;
			side2_s9 <= d2_side;
		end
	end

	// ------------------------------------------------------------------
	// s10: x1 * 3038 >> 16 and x2 >> 16
	// ------------------------------------------------------------------
	logic signed [31:0] k1_prod;

	assign k1_prod = x1sq_s9 * C_P_K1;

	logic               vld_s10;
	logic signed [31:0] p_s10, x1_s10, x2_s10;
	side2_t             side2_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s10     <= p_s9;
			x1_s10    <= k1_prod >>> 16;
			x2_s10    <= m2_s9 >>> 16;
			side2_s10 <= side2_s9;
		end
	end

	// ------------------------------------------------------------------
	// Output register: final correction, saturation, fault forcing
	// ------------------------------------------------------------------
	logic signed [31:0] p_fin;
	logic [19:0]        p_sat;

	always_comb begin
		p_fin = p_s10 + ((x1_s10 + x2_s10 + C_P_K3) >>> 4);
		if (p_fin[31]) begin
			p_sat = '0;
		end else if (p_fin > C_P_MAX) begin
			p_sat = C_P_MAX[19:0];
		end else begin
			p_sat = p_fin[19:0];
		end
	end

	logic signed [15:0] temp_q;
	logic [19:0]        press_q;
	logic               fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fault_q <= side2_s10.fault;
			temp_q  <= side2_s10.fault ? 16'sd0 : side2_s10.t16;
			press_q <= side2_s10.fault ? 20'd0 : p_sat;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.temp_tenths = temp_q;
	assign result.pressure_pa = press_q;
	assign result.div_fault   = fault_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.div_fault |-> result.temp_tenths == 16'sd0
			&& result.pressure_pa == 20'd0)
		else $error("fault result carries nonzero values");

	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s10 |=> out_valid_q)
		else $error("last stage item did not reach output register");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(d2_valid) && $stable(vld_s8) && $stable(temp_q))
		else $error("pipeline moved during stall");

endmodule

`default_nettype wire

@@ tb/tb_baro_temp_pressure_compensation_unit.sv @@
// ----------------------------------------------------------------------------
// tb_baro_temp_pressure_compensation_unit
// Self-checking bench for the barometer compensation unit. Each phase after
// the first writes all calibration words and the oversampling setting while
// the unit is idle, then streams raw samples through the sample channel. A
// bit-accurate predictor, or the row of a typed sample, queues the expected
// reading of every accepted sample. Each result transaction is checked
// against the oldest queued reading.
`default_nettype none

module tb_baro_temp_pressure_compensation_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import bptc_pkg::*;

	localparam int          WATCHDOG_LIMIT = 4000; // cycles with no transaction at all
	localparam int          DRAIN_CYCLES   = 100;  // pipe is 75 deep
	localparam int          RANDOM_PER_PH  = 180;
	localparam int          NUM_PHASES     = 9;
	localparam logic [2:0]  REG_SPARE6     = 3'd6; // unmapped, writes dropped
	localparam logic [2:0]  REG_SPARE7     = 3'd7;

	// Typical factory calibration set, one packed word per register
	localparam logic [31:0] CAL_TYP_AC1_AC2 = 32'h0198_FFB8; // 408, -72
	localparam logic [31:0] CAL_TYP_AC3_AC4 = 32'hC7D1_7FE5; // -14383, 32741
	localparam logic [31:0] CAL_TYP_AC5_AC6 = 32'h7FF5_5A71; // 32757, 23153
	localparam logic [31:0] CAL_TYP_B1_B2   = 32'h182E_0004; // 6190, 4
	localparam logic [31:0] CAL_TYP_MC_MD   = 32'hDDF9_0B34; // -8711, 2868

	typedef struct packed {
		logic signed [15:0] temp_tenths;
		logic [19:0]        pressure_pa;
		logic               div_fault;
	} reading_t;

	typedef struct {
		logic [15:0] raw_temp;
		logic [23:0] raw_press;
		bit          typed;    // expected value given in the row
		reading_t    reading;
	} sample_row_t;

	logic clk;
	logic arst_n;

	bptc_sample_if sample_ch();
	bptc_result_if result_ch();
	bptc_cfg_if    cfg_ch();

	baro_temp_pressure_compensation_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Mirror of the register file, updated on each cfg transaction
	logic [31:0] cal_word [5];
	logic [1:0]  oss_mirror;

	reading_t    readings_due [$];
	int          err_count;
	bit          no_idle;        // suppresses random idling on both sides

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic longint wrap32(input longint v);
		return longint'(signed'(v[31:0]));
	endfunction

	function automatic longint hs(input logic [15:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic reading_t compensate(input logic [15:0] raw_temp,
			input logic [23:0] raw_press);
		longint      ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
		longint      ut, x1, x2, x3, b3, b5, b6, bsq, t, p, den;
		logic [31:0] ac4, up, b3u, diff, b4, b7, q, scale, x3b;
		logic [63:0] prod;
		reading_t    r;

		ac1 = hs(cal_word[0][31:16]);
		ac2 = hs(cal_word[0][15:0]);
		ac3 = hs(cal_word[1][31:16]);
		ac4 = {16'd0, cal_word[1][15:0]};
		ac5 = longint'(cal_word[2][31:16]);
		ac6 = longint'(cal_word[2][15:0]);
		b1  = hs(cal_word[3][31:16]);
		b2  = hs(cal_word[3][15:0]);
		mc  = hs(cal_word[4][31:16]);
		md  = hs(cal_word[4][15:0]);
		ut  = longint'(raw_temp);
		up  = 32'(raw_press >> (4'd8 - oss_mirror));
		r   = '0;

		// temperature
		x1  = wrap32(ut - ac6);
		x1  = wrap32(x1 * ac5) / 32768;
		den = wrap32(x1 + md);
		if (den == 0) begin
			r.div_fault = 1'b1;
			return r;
		end
		x2 = wrap32(wrap32(mc * 2048) / den);
		b5 = wrap32(x1 + x2);
		t  = wrap32(b5 + 8) / 16;

		// pressure coefficients
		b6  = wrap32(b5 - longint'(C_B6_OFFSET));
		bsq = wrap32(b6 * b6) >>> 12;
		x1  = wrap32(b2 * bsq) >>> 11;
		x2  = wrap32(ac2 * b6) >>> 11;
		x3  = wrap32(x1 + x2);
		b3  = wrap32(wrap32(ac1 * 4) + x3);
		b3  = wrap32(b3 * (longint'(1) << oss_mirror));
		b3  = wrap32(b3 + 2) / 4;
		x1  = wrap32(ac3 * b6) >>> 13;
		x2  = wrap32(b1 * bsq) >>> 16;   // published order: square first
		x3  = wrap32(wrap32(x1 + x2) + 2) >>> 2;
		x3b = 32'(wrap32(x3 + longint'(C_AC4_BIAS)));
		prod = 64'(ac4) * 64'(x3b);
		b4  = {15'd0, prod[31:15]};
		if (b4 == 32'd0) begin
			r.div_fault = 1'b1;
			return r;
		end
		b3u   = 32'(b3);
		diff  = up - b3u;
		scale = C_B7_SCALE >> oss_mirror;
		prod  = 64'(diff) * 64'(scale);
		b7    = prod[31:0];
		if (b7 < C_MSB32)
			q = (b7 * 32'd2) / b4;
		else
			q = (b7 / b4) * 32'd2;
		p = longint'(signed'(q));

		// pressure polynomial
		x1 = p >>> 8;
		x1 = wrap32(x1 * x1);
		x1 = wrap32(x1 * longint'(C_P_K1)) >>> 16;
		x2 = wrap32(longint'(C_P_K2) * p) >>> 16;
		p  = wrap32(p + (wrap32(wrap32(x1 + x2) + longint'(C_P_K3)) >>> 4));

		if (t > longint'(C_T_MAX)) t = longint'(C_T_MAX);
		if (t < longint'(C_T_MIN)) t = longint'(C_T_MIN);
		if (p < 0) p = 0;
		if (p > longint'(C_P_MAX)) p = longint'(C_P_MAX);
		r.temp_tenths = 16'(t);
		r.pressure_pa = 20'(p);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Clock, watchdog
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	int quiet_cycles;
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d readings outstanding", $realtime,
					readings_due.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result side: random backpressure, checking against the oldest reading
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		result_ch.ready <= no_idle || ($urandom_range(99) >= 33);
	end

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (readings_due.size() == 0) begin
				$display("%0t: unexpected result t=%0d p=%0d f=%0b", $realtime,
					result_ch.temp_tenths, result_ch.pressure_pa, result_ch.div_fault);
				err_count++;
			end else begin
				want = readings_due.pop_front();
				if (result_ch.temp_tenths !== want.temp_tenths) begin
					$display("%0t: temp_tenths expected %0d actual %0d", $realtime,
						want.temp_tenths, result_ch.temp_tenths);
					err_count++;
				end
				if (result_ch.pressure_pa !== want.pressure_pa) begin
					$display("%0t: pressure_pa expected %0d actual %0d", $realtime,
						want.pressure_pa, result_ch.pressure_pa);
					err_count++;
				end
				if (result_ch.div_fault !== want.div_fault) begin
					$display("%0t: div_fault expected %0b actual %0b", $realtime,
						want.div_fault, result_ch.div_fault);
					err_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_sample(input logic [15:0] raw_temp, input logic [23:0] raw_press,
			input bit typed, input reading_t typed_reading);
		while (!no_idle && $urandom_range(99) < 33) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.raw_temp  <= raw_temp;
		sample_ch.raw_press <= raw_press;
		do @(posedge clk); while (!sample_ch.ready);
		readings_due.push_back(typed ? typed_reading : compensate(raw_temp, raw_press));
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (index)
			REG_AC1_AC2:   cal_word[0] = data;
			REG_AC3_AC4:   cal_word[1] = data;
			REG_AC5_AC6:   cal_word[2] = data;
			REG_B1_B2:     cal_word[3] = data;
			REG_MC_MD:     cal_word[4] = data;
			REG_OVERSAMPL: oss_mirror  = data[1:0];
			default: ;     // spare indexes are ignored by the unit
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (readings_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Nudge both halves of a calibration word around its typical value
	function automatic logic [31:0] jitter(input logic [31:0] w);
		logic [15:0] hi, lo;
		hi = w[31:16] + 16'($urandom_range(512)) - 16'd256;
		lo = w[15:0]  + 16'($urandom_range(512)) - 16'd256;
		return {hi, lo};
	endfunction

	task automatic load_cal(input logic [31:0] w0, input logic [31:0] w1,
			input logic [31:0] w2, input logic [31:0] w3, input logic [31:0] w4,
			input logic [31:0] oss);
		write_reg(REG_AC1_AC2, w0);
		write_reg(REG_AC3_AC4, w1);
		write_reg(REG_AC5_AC6, w2);
		write_reg(REG_B1_B2, w3);
		write_reg(REG_MC_MD, w4);
		write_reg(REG_OVERSAMPL, oss);
		// spare indexes must leave the mirror untouched
		write_reg(REG_SPARE6, $urandom());
		write_reg(REG_SPARE7, $urandom());
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	sample_row_t fault_rows [6];
	sample_row_t typ_rows   [4];

	initial begin
		logic [15:0] rt;
		logic [23:0] rp;
		reading_t    none;

		none       = '0;
		err_count  = 0;
		no_idle    = 1'b0;
		quiet_cycles = 0;
		arst_n     = 1'b0;
		sample_ch.valid     = 1'b0;
		sample_ch.raw_temp  = '0;
		sample_ch.raw_press = '0;
		result_ch.ready     = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_AC1_AC2;
		cfg_ch.data  = '0;
		foreach (cal_word[i]) cal_word[i] = '0;
		oss_mirror = 2'd3;

		// After reset every calibration word is zero: x1 is 0, md is 0,
		// so the temperature divisor is zero for any sample.
		fault_rows[0] = '{16'h0000, 24'h000000, 1'b1, '{16'sd0, 20'd0, 1'b1}};
		fault_rows[1] = '{16'hFFFF, 24'hFFFFFF, 1'b1, '{16'sd0, 20'd0, 1'b1}};
		fault_rows[2] = '{16'h5555, 24'hAAAAAA, 1'b1, '{16'sd0, 20'd0, 1'b1}};
		fault_rows[3] = '{16'hAAAA, 24'h555555, 1'b1, '{16'sd0, 20'd0, 1'b1}};
		fault_rows[4] = '{16'h8000, 24'h800000, 1'b1, '{16'sd0, 20'd0, 1'b1}};
		fault_rows[5] = '{16'h7FFF, 24'h7FFFFF, 1'b1, '{16'sd0, 20'd0, 1'b1}};

		// Typical calibration at oversampling 0: the textbook worked example
		// gives 15.0 C and 69964 Pa.
		typ_rows[0] = '{16'd27898, 24'd6103808, 1'b1, '{16'sd150, 20'd69964, 1'b0}};
		typ_rows[1] = '{16'h0000, 24'h000000, 1'b0, none};
		typ_rows[2] = '{16'hFFFF, 24'hFFFFFF, 1'b0, none};
		typ_rows[3] = '{16'h6C00, 24'h5D0000, 1'b0, none};

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (fault_rows[i])
			send_sample(fault_rows[i].raw_temp, fault_rows[i].raw_press,
				fault_rows[i].typed, fault_rows[i].reading);
		wait_drained();

		for (int ph = 1; ph < NUM_PHASES; ph++) begin
			case (ph)
				1, 7: load_cal(CAL_TYP_AC1_AC2, CAL_TYP_AC3_AC4, CAL_TYP_AC5_AC6,
					CAL_TYP_B1_B2, CAL_TYP_MC_MD, 32'd0);
				2, 3, 4: load_cal(jitter(CAL_TYP_AC1_AC2), jitter(CAL_TYP_AC3_AC4),
					jitter(CAL_TYP_AC5_AC6), jitter(CAL_TYP_B1_B2), jitter(CAL_TYP_MC_MD),
					32'(ph - 1));
				5: load_cal('1, '1, '1, '1, '1, 32'd3);           // all-ones extreme
				6: load_cal($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom());
				default: begin
					// ac4 of zero: b4 is always zero, pressure divisor fault
					load_cal($urandom(), {16'($urandom_range(65535)), 16'h0000},
						$urandom(), $urandom(), $urandom(), $urandom());
				end
			endcase

			if (ph == 1)
				foreach (typ_rows[i])
					send_sample(typ_rows[i].raw_temp, typ_rows[i].raw_press,
						typ_rows[i].typed, typ_rows[i].reading);

			// long stretch with no idling on either side
			no_idle = (ph == 4);

			for (int n = 0; n < RANDOM_PER_PH; n++) begin
				// the sender holds off until the pipe has fully emptied
				if (ph == 7 && n == RANDOM_PER_PH / 2) begin
					sample_ch.valid <= 1'b0;
					while (readings_due.size() != 0) @(negedge clk);
				end
				if ($urandom_range(99) < 70) begin
					// plausible sensor readings near room conditions
					rt = 16'($urandom_range(32000, 22000));
					rp = 24'($urandom_range(24'hB0_0000, 24'h40_0000));
				end else begin
					rt = 16'($urandom());
					rp = 24'($urandom());
				end
				send_sample(rt, rp, 1'b0, none);
			end
			wait_drained();
			no_idle = 1'b0;
		end

		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
